// File: sv/cpool_pkg.sv
// ----------------------------------------------------------------------------
// cpool_pkg
// shared widths, codes and state type for the collection pooling block
// ----------------------------------------------------------------------------
package cpool_pkg;

  // store geometry
  localparam int MAX_POSITIONS = 4096;
  localparam int POS_W         = $clog2(MAX_POSITIONS);

  // field widths
  localparam int VAL_W      = 16;
  localparam int IMG_W      = 16;
  localparam int ACC_W      = 32;
  localparam int MAP_SIZE_W = 13;
  localparam int SEEN_W     = 16;
  localparam int DIVS_W     = SEEN_W + 1;

  // stream widths; data in whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_POOL_MODE = 1'b0;
  localparam logic REG_MAP_SIZE  = 1'b1;
  localparam logic [MAP_SIZE_W-1:0] MAP_SIZE_RESET = 13'd4096;

  // pooling modes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = ACC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_PUSH
  } cp_state_t;

endpackage

// File: sv/collection_pooling.sv
// ----------------------------------------------------------------------------
// collection_pooling
// elementwise max or average pooling over a collection of feature maps
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | tdata: value, position, image_index; tuser: first_map, last_map
//  out_    | out | tdata: pooled_value, best_index, out_position; tlast: last_of_map
//  cfg_    | in  | apb register writes and reads: pool_mode, map_size
//
//  an item without result is accepted with a memory read in idle, then the
//  running store is read-modify-written in modify. a max-mode result then
//  loads the output register in push; an average-mode result first runs the
//  bit-serial divider (one quotient bit per cycle), then that load.
//  a waiting result lets the next beat in; a second one stalls in push.
//  reset is synchronous, active low; the stores are not cleared.
// ----------------------------------------------------------------------------
module collection_pooling (
  input  logic                                clk,
  input  logic                                rst_n,
  // value [15:0], position [27:16], image_index [43:28], zero pad [47:44]
  input  logic [cpool_pkg::IN_DATA_W-1:0]     in_tdata,
  // first_map [0], last_map [1]
  input  logic [cpool_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pooled_value [15:0], best_index [31:16], out_position [43:32], zero pad [47:44]
  output logic [cpool_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cpool_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [cpool_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [cpool_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  import cpool_pkg::*;

  // configuration registers
  logic                  pool_mode_r;
  logic [MAP_SIZE_W-1:0] map_size_r;
  logic                  cfg_wr;
  logic                  cfg_sel;

  // state machine
  cp_state_t state_r, state_nxt;
  logic      in_fire;
  logic      mem_we;
  logic      div_load;
  logic      out_load;
  logic      div_done;

  // captured item
  logic signed [VAL_W-1:0] val_r;
  logic [POS_W-1:0]        pos_r;
  logic [IMG_W-1:0]        img_r;
  logic                    first_r;
  logic                    last_r;

  // running store, index in the upper bits
  logic [IMG_W+ACC_W-1:0] mem [MAX_POSITIONS];
  logic [IMG_W+ACC_W-1:0] mem_q_r;

  logic [SEEN_W-1:0] maps_seen_r;

  // modify stage
  logic signed [ACC_W-1:0] rd_acc;
  logic [IMG_W-1:0]        rd_idx;
  logic signed [ACC_W-1:0] v_ext;
  logic signed [ACC_W:0]   sum_w;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] acc_new;
  logic [IMG_W-1:0]        idx_new;
  logic                    map_end;
  logic [SEEN_W-1:0]       prior_seen;
  logic [ACC_W-1:0]        acc_mag;

  // divider
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [ACC_W-1:0]     dq_r;
  logic [SEEN_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    dvs_r;
  logic                 neg_r;
  logic [DIVS_W-1:0]    trial;
  logic                 q_bit;
  logic [ACC_W-1:0]     q_nxt;
  logic [VAL_W-1:0]     q_sat;

  // result holding
  logic [VAL_W-1:0] res_val_r;
  logic [IMG_W-1:0] res_idx_r;
  logic             res_last_r;

  // output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tlast_r;

  // saturate a 32-bit word to 16 bits
  function automatic logic [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] a);
    logic [VAL_W-1:0] r;
    if (a > ACC_W'(32767)) begin
      r = 16'h7FFF;
    end else if (a < -ACC_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = a[VAL_W-1:0];
    end
    return r;
  endfunction

  // apb register access
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_sel)
      REG_POOL_MODE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, pool_mode_r};
      REG_MAP_SIZE:  cfg_prdata = {{(CFG_DATA_W-MAP_SIZE_W){1'b0}}, map_size_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_mode_r <= MODE_MAX;
      map_size_r  <= MAP_SIZE_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_POOL_MODE: pool_mode_r <= cfg_pwdata[0];
        REG_MAP_SIZE:  map_size_r  <= cfg_pwdata[MAP_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (pool_mode_r == MODE_AVG) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    div_load  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MOD: begin
        mem_we   = 1'b1;
        div_load = last_r & (pool_mode_r == MODE_AVG);
      end
      ST_DIV: ;
      ST_PUSH: out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign in_fire  = in_tvalid & in_tready;
  assign div_done = (state_r == ST_DIV) && (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r   <= in_tdata[15:0];
      pos_r   <= in_tdata[16 +: POS_W];
      img_r   <= in_tdata[43:28];
      first_r <= in_tuser[0];
      last_r  <= in_tuser[1];
    end
  end

  // running store: read on accept, write back in the modify cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_r] <= {idx_new, acc_new};
    end
    mem_q_r <= mem[in_tdata[16 +: POS_W]];
  end

  // modify: first-map load, compare or saturating add
  assign rd_acc  = mem_q_r[ACC_W-1:0];
  assign rd_idx  = mem_q_r[ACC_W +: IMG_W];
  assign v_ext   = ACC_W'(val_r);
  assign sum_w   = {rd_acc[ACC_W-1], rd_acc} + {v_ext[ACC_W-1], v_ext};
  assign sum_sat = (sum_w[ACC_W] != sum_w[ACC_W-1])
                   ? {sum_w[ACC_W], {(ACC_W-1){~sum_w[ACC_W]}}}
                   : sum_w[ACC_W-1:0];

  always_comb begin
    acc_new = rd_acc;
    idx_new = rd_idx;
    if (first_r) begin
      acc_new = v_ext;
      idx_new = img_r;
    end else if (pool_mode_r == MODE_AVG) begin
      acc_new = sum_sat;
    end else if (v_ext > rd_acc) begin
      acc_new = v_ext;
      idx_new = img_r;
    end
  end

  assign map_end    = ({1'b0, pos_r} + MAP_SIZE_W'(1)) == map_size_r;
  assign prior_seen = first_r ? '0 : maps_seen_r;
  assign acc_mag    = acc_new[ACC_W-1] ? (ACC_W'(0) - acc_new) : acc_new;

  // map counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maps_seen_r <= '0;
    end else if (mem_we && map_end) begin
      if (last_r) begin
        maps_seen_r <= '0;
      end else if (prior_seen == {SEEN_W{1'b1}}) begin
        maps_seen_r <= prior_seen;
      end else begin
        maps_seen_r <= prior_seen + SEEN_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_r, dq_r[ACC_W-1]};
  assign q_bit = trial >= dvs_r;
  assign q_nxt = {dq_r[ACC_W-2:0], q_bit};

  always_comb begin
    if (neg_r) begin
      q_sat = (q_nxt > ACC_W'(32768)) ? 16'h8000 : (VAL_W'(0) - q_nxt[VAL_W-1:0]);
    end else begin
      q_sat = (q_nxt > ACC_W'(32767)) ? 16'h7FFF : q_nxt[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_load) begin
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      dq_r  <= acc_mag;
      rem_r <= '0;
      dvs_r <= {1'b0, prior_seen} + DIVS_W'(1);
      neg_r <= acc_new[ACC_W-1];
    end else if (state_r == ST_DIV) begin
      dq_r  <= q_nxt;
      rem_r <= q_bit ? SEEN_W'(trial - dvs_r) : trial[SEEN_W-1:0];
    end
  end

  // result holding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      res_val_r  <= sat16(acc_new);
      res_idx_r  <= (pool_mode_r == MODE_AVG) ? '0 : idx_new;
      res_last_r <= map_end;
    end else if (div_done) begin
      res_val_r <= q_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {{(OUT_DATA_W-VAL_W-IMG_W-POS_W){1'b0}}, pos_r, res_idx_r, res_val_r};
      out_tlast_r <= res_last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef NO_ASSERTIONS
  // a result beat only appears after the push cycle
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_PUSH))
    else $error("result beat raised outside push");

  // divider finishes into the push state
  a_div_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |=> state_r == ST_PUSH)
    else $error("divider did not hand over to push");

  // the last map closes the collection
  a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && map_end && last_r) |=> maps_seen_r == '0)
    else $error("map counter not cleared at collection end");

  // no beat is taken while an item is still in work
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD || state_r == ST_DIV) |-> !in_tready)
    else $error("input taken during item work");
`endif

endmodule
